@@ rtl/core/miller_rabin_witness_test_top_defines.svh @@
// Assertion macros used by the top-level file to check the block.
`ifndef MILLER_RABIN_WITNESS_TEST_TOP_DEFINES_SVH
`define MILLER_RABIN_WITNESS_TEST_TOP_DEFINES_SVH

// The consequent must hold in the cycle after the antecedent.
`define MRW_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

// The consequent must hold in the same cycle as the antecedent.
`define MRW_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

`endif

@@ rtl/core/mrw_pkg.sv @@
package mrw_pkg;

	// Datapath operations issued by the controller.
	localparam logic [2:0] OP_NONE  = 3'd0;
	localparam logic [2:0] OP_LOAD  = 3'd1;
	localparam logic [2:0] OP_SPLIT = 3'd2;
	localparam logic [2:0] OP_RED   = 3'd3;
	localparam logic [2:0] OP_MACC  = 3'd4;
	localparam logic [2:0] OP_MSQB  = 3'd5;
	localparam logic [2:0] OP_MSQX  = 3'd6;

	// Where a finished modular product is written.
	localparam logic DEST_B   = 1'b0;
	localparam logic DEST_ACC = 1'b1;

	typedef struct packed {
		logic [2:0] op;
	} cmd_t;

	typedef struct packed {
		logic n_is_two;
		logic n_is_one;
		logic n_even;
		logic d_odd;
		logic e_zero;
		logic e_lsb;
		logic mul_done;
		logic acc_is_one;
		logic prev_is_nm1;
		logic k_lt_s;
	} sts_t;

endpackage

@@ rtl/core/mrw_mulmod.sv @@
module mrw_mulmod #(
	parameter int W = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] x,
	input  logic [W-1:0] y,
	input  logic [W-1:0] n,
	output logic         done,
	output logic [W-1:0] r
);

	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  x_q, y_q, r_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q, done_q;
	logic [W:0]    r2, r2m, t, tm;

	// One multiplier bit per cycle, most significant first: r = 2r + bit*x, kept below n.
	always_comb begin
		r2  = {r_q, 1'b0};
		r2m = (r2 >= {1'b0, n}) ? r2 - {1'b0, n} : r2;
		t   = r2m + (y_q[W-1] ? {1'b0, x_q} : {(W+1){1'b0}});
		tm  = (t >= {1'b0, n}) ? t - {1'b0, n} : t;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= x;
			y_q <= y;
			r_q <= '0;
		end else if (busy_q) begin
			r_q <= tm[W-1:0];
			y_q <= {y_q[W-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign r    = r_q;

endmodule

@@ rtl/core/mrw_datapath.sv @@
module mrw_datapath #(
	parameter int W = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  mrw_pkg::cmd_t       cmd,
	input  logic [W-1:0]        candidate,
	input  logic [W-1:0]        witness,
	output mrw_pkg::sts_t       sts
);

	localparam int SW = $clog2(W);

	logic [W-1:0]  n_q, a_q, e_q, b_q, acc_q, prev_q;
	logic [SW-1:0] s_q, k_q;
	logic          dest_q;
	logic          mul_start, mul_done;
	logic [W-1:0]  mul_x, mul_y, mul_r;

	always_comb begin
		mul_start = 1'b0;
		mul_x     = b_q;
		mul_y     = b_q;
		unique case (cmd.op)
			mrw_pkg::OP_RED: begin
				mul_start = 1'b1;
				mul_x     = W'(1);
				mul_y     = a_q;
			end
			mrw_pkg::OP_MACC: begin
				mul_start = 1'b1;
				mul_x     = acc_q;
				mul_y     = b_q;
			end
			mrw_pkg::OP_MSQB: begin
				mul_start = 1'b1;
			end
			mrw_pkg::OP_MSQX: begin
				mul_start = 1'b1;
				mul_x     = acc_q;
				mul_y     = acc_q;
			end
			default: begin
				mul_start = 1'b0;
			end
		endcase
	end

	mrw_mulmod #(.W(W)) u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.x      (mul_x),
		.y      (mul_y),
		.n      (n_q),
		.done   (mul_done),
		.r      (mul_r)
	);

	always_ff @(posedge clk) begin
		if (mul_done) begin
			if (dest_q == mrw_pkg::DEST_ACC) begin
				acc_q <= mul_r;
			end else begin
				b_q <= mul_r;
			end
		end
		unique case (cmd.op)
			mrw_pkg::OP_LOAD: begin
				n_q   <= candidate;
				a_q   <= witness;
				e_q   <= candidate - W'(1);
				s_q   <= '0;
				k_q   <= '0;
				acc_q <= W'(1);
			end
			mrw_pkg::OP_SPLIT: begin
				e_q <= {1'b0, e_q[W-1:1]};
				s_q <= s_q + 1'b1;
			end
			mrw_pkg::OP_RED: begin
				dest_q <= mrw_pkg::DEST_B;
			end
			mrw_pkg::OP_MACC: begin
				dest_q <= mrw_pkg::DEST_ACC;
			end
			mrw_pkg::OP_MSQB: begin
				dest_q <= mrw_pkg::DEST_B;
				e_q    <= {1'b0, e_q[W-1:1]};
			end
			mrw_pkg::OP_MSQX: begin
				dest_q <= mrw_pkg::DEST_ACC;
				prev_q <= acc_q;
				k_q    <= k_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		sts.n_is_two    = (n_q == W'(2));
		sts.n_is_one    = (n_q == W'(1));
		sts.n_even      = ~n_q[0];
		sts.d_odd       = e_q[0];
		sts.e_zero      = (e_q == '0);
		sts.e_lsb       = e_q[0];
		sts.mul_done    = mul_done;
		sts.acc_is_one  = (acc_q == W'(1));
		sts.prev_is_nm1 = (prev_q == n_q - W'(1));
		sts.k_lt_s      = (k_q < s_q);
	end

endmodule

@@ rtl/core/mrw_ctrl.sv @@
module mrw_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	output logic          probable_prime,
	input  mrw_pkg::sts_t sts,
	output mrw_pkg::cmd_t cmd
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_CLASS = 4'd1;
	localparam logic [3:0] S_SPLIT = 4'd2;
	localparam logic [3:0] S_RWAIT = 4'd3;
	localparam logic [3:0] S_PWR   = 4'd4;
	localparam logic [3:0] S_MWAIT = 4'd5;
	localparam logic [3:0] S_SWAIT = 4'd6;
	localparam logic [3:0] S_CHK   = 4'd7;
	localparam logic [3:0] S_SQ    = 4'd8;
	localparam logic [3:0] S_QWAIT = 4'd9;
	localparam logic [3:0] S_QCHK  = 4'd10;
	localparam logic [3:0] S_FIN   = 4'd11;

	logic [3:0] state_q, state_d;
	logic       res_q, res_d;
	logic       ov_q, pp_q;
	logic       slot_free;

	assign in_stall  = (state_q != S_IDLE);
	assign slot_free = !ov_q || !out_stall;

	always_comb begin
		state_d = state_q;
		res_d   = res_q;
		cmd.op  = mrw_pkg::OP_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = mrw_pkg::OP_LOAD;
					state_d = S_CLASS;
				end
			end
			S_CLASS: begin
				if (sts.n_is_two) begin
					res_d   = 1'b1;
					state_d = S_FIN;
				end else if (sts.n_even || sts.n_is_one) begin
					res_d   = 1'b0;
					state_d = S_FIN;
				end else begin
					state_d = S_SPLIT;
				end
			end
			S_SPLIT: begin
				if (sts.d_odd) begin
					cmd.op  = mrw_pkg::OP_RED;
					state_d = S_RWAIT;
				end else begin
					cmd.op = mrw_pkg::OP_SPLIT;
				end
			end
			S_RWAIT: begin
				if (sts.mul_done) begin
					state_d = S_PWR;
				end
			end
			S_PWR: begin
				if (sts.e_zero) begin
					state_d = S_CHK;
				end else if (sts.e_lsb) begin
					cmd.op  = mrw_pkg::OP_MACC;
					state_d = S_MWAIT;
				end else begin
					cmd.op  = mrw_pkg::OP_MSQB;
					state_d = S_SWAIT;
				end
			end
			S_MWAIT: begin
				if (sts.mul_done) begin
					cmd.op  = mrw_pkg::OP_MSQB;
					state_d = S_SWAIT;
				end
			end
			S_SWAIT: begin
				if (sts.mul_done) begin
					state_d = S_PWR;
				end
			end
			S_CHK: begin
				if (sts.acc_is_one) begin
					res_d   = 1'b1;
					state_d = S_FIN;
				end else begin
					state_d = S_SQ;
				end
			end
			S_SQ: begin
				if (sts.k_lt_s) begin
					cmd.op  = mrw_pkg::OP_MSQX;
					state_d = S_QWAIT;
				end else begin
					res_d   = sts.acc_is_one && sts.prev_is_nm1;
					state_d = S_FIN;
				end
			end
			S_QWAIT: begin
				if (sts.mul_done) begin
					state_d = S_QCHK;
				end
			end
			S_QCHK: begin
				if (sts.acc_is_one) begin
					res_d   = sts.prev_is_nm1;
					state_d = S_FIN;
				end else begin
					state_d = S_SQ;
				end
			end
			S_FIN: begin
				if (slot_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_FIN && slot_free) begin
				ov_q <= 1'b1;
			end else if (!out_stall) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_d;
		if (state_q == S_FIN && slot_free) begin
			pp_q <= res_q;
		end
	end

	assign out_valid      = ov_q;
	assign probable_prime = pp_q;

endmodule

@@ rtl/core/miller_rabin_witness_test_top.sv @@
// A candidate of 0, 1, 2 or any even value is settled by classification alone; an odd
// candidate above 1 needs more time as s and the bit length of d grow, where candidate
// minus one is d * 2^s with d odd. Throughput: one word at a time, the next word is
// taken once the previous result sits in the output register.
// Reset: arst_n low clears the controller and the output valid at once; no clearing pass.
`include "miller_rabin_witness_test_top_defines.svh"

module miller_rabin_witness_test_top #(
	parameter int NUM_WIDTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [NUM_WIDTH-1:0] candidate,
	input  logic [NUM_WIDTH-1:0] witness,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 probable_prime
);

	// The controller sequences the round: it classifies the candidate, strips the
	// trailing zeros of n-1 one bit per cycle, reduces the witness, runs the
	// square-and-multiply power and then the squaring chain. The datapath holds the
	// operands and a single shared modular multiplier that consumes one multiplier
	// bit per cycle; every modular product passes through that unit, which sets the
	// rate of the whole block.
	mrw_pkg::cmd_t cmd;
	mrw_pkg::sts_t sts;

	mrw_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.probable_prime (probable_prime),
		.sts            (sts),
		.cmd            (cmd)
	);

	// The datapath captures the input word when the controller issues its load.
	mrw_datapath #(.W(NUM_WIDTH)) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.candidate (candidate),
		.witness   (witness),
		.sts       (sts)
	);

	// An accepted word always keeps the block busy in the following cycle.
	`MRW_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
	// A fresh result only appears after the block has been working on a word.
	`MRW_ASSERT_NOW(a_result_from_work, $rose(out_valid), $past(in_stall))
	// The multiplier never reports completion while the controller is idle.
	`MRW_ASSERT_NOW(a_no_stray_product, sts.mul_done, in_stall)

endmodule
